FILE: rtl/core/tfn_pkg.sv
// shared types and constants for the triangle face normal block
package tfn_pkg;

   // field and datapath widths
   localparam int CoordW = 24;   // vertex coordinate, signed q15.8
   localparam int EdgeW  = 25;   // edge vector component
   localparam int ProdW  = 50;   // edge component product
   localparam int CrossW = 51;   // cross product component
   localparam int MagW   = 30;   // scaled magnitude, below 2^30
   localparam int SqW    = 60;   // square of a scaled magnitude
   localparam int SumW   = 62;   // sum of three squares
   localparam int RemW   = 96;   // signed remainder of the digit recurrence
   localparam int QuotW  = 15;   // unsigned result magnitude
   localparam int NormW  = 16;   // signed q1.14 result
   localparam int ShiftW = 5;    // scaling shift, 0 to 21
   localparam int LimitBit = 30; // magnitudes are scaled below 2^LimitBit
   localparam int Iters  = 15;   // one result bit per recurrence step

   // one request: three vertices
   typedef struct packed {
      logic signed [CoordW-1:0] a_x;
      logic signed [CoordW-1:0] a_y;
      logic signed [CoordW-1:0] a_z;
      logic signed [CoordW-1:0] b_x;
      logic signed [CoordW-1:0] b_y;
      logic signed [CoordW-1:0] b_z;
      logic signed [CoordW-1:0] c_x;
      logic signed [CoordW-1:0] c_y;
      logic signed [CoordW-1:0] c_z;
   } req_type;

   // one response: unit normal and degenerate flag
   typedef struct packed {
      logic signed [NormW-1:0] normal_x;
      logic signed [NormW-1:0] normal_y;
      logic signed [NormW-1:0] normal_z;
      logic                    degenerate;
   } rsp_type;

   // exact cross product handed from the front end
   typedef struct packed {
      logic signed [CrossW-1:0] n_x;
      logic signed [CrossW-1:0] n_y;
      logic signed [CrossW-1:0] n_z;
   } cross_type;

endpackage

FILE: rtl/core/tfn_cross.sv
// front end: edge vectors and exact cross product in three stages
module tfn_cross (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  logic               in_valid,
   input  tfn_pkg::req_type   in_item,
   output logic               out_valid,
   output tfn_pkg::cross_type out_item
);
   import tfn_pkg::*;

   logic signed [EdgeW-1:0]  e1_in [3];
   logic signed [EdgeW-1:0]  e2_in [3];
   logic signed [EdgeW-1:0]  e1_ff [3];
   logic signed [EdgeW-1:0]  e2_ff [3];
   logic signed [ProdW-1:0]  pr_in [6];
   logic signed [ProdW-1:0]  pr_ff [6];
   logic signed [CrossW-1:0] n_in [3];
   logic signed [CrossW-1:0] n_ff [3];
   logic [2:0]               v_ff;

   // edge vectors a - b and c - b
   always_comb begin
      e1_in[0] = EdgeW'(in_item.a_x) - EdgeW'(in_item.b_x);
      e1_in[1] = EdgeW'(in_item.a_y) - EdgeW'(in_item.b_y);
      e1_in[2] = EdgeW'(in_item.a_z) - EdgeW'(in_item.b_z);
      e2_in[0] = EdgeW'(in_item.c_x) - EdgeW'(in_item.b_x);
      e2_in[1] = EdgeW'(in_item.c_y) - EdgeW'(in_item.b_y);
      e2_in[2] = EdgeW'(in_item.c_z) - EdgeW'(in_item.b_z);
   end

   // six partial products of the cross product
   always_comb begin
      pr_in[0] = e1_ff[1] * e2_ff[2];
      pr_in[1] = e1_ff[2] * e2_ff[1];
      pr_in[2] = e1_ff[2] * e2_ff[0];
      pr_in[3] = e1_ff[0] * e2_ff[2];
      pr_in[4] = e1_ff[0] * e2_ff[1];
      pr_in[5] = e1_ff[1] * e2_ff[0];
   end

   // pairwise differences give the components
   always_comb begin
      n_in[0] = CrossW'(pr_ff[0]) - CrossW'(pr_ff[1]);
      n_in[1] = CrossW'(pr_ff[2]) - CrossW'(pr_ff[3]);
      n_in[2] = CrossW'(pr_ff[4]) - CrossW'(pr_ff[5]);
   end

   // valid bits travel with the data
   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[1:0], in_valid};
      end
   end

   // stage data
   always_ff @(posedge clock) begin
      if (en) begin
         e1_ff <= e1_in;
         e2_ff <= e2_in;
         pr_ff <= pr_in;
         n_ff  <= n_in;
      end
   end

   assign out_valid      = v_ff[2];
   assign out_item.n_x   = n_ff[0];
   assign out_item.n_y   = n_ff[1];
   assign out_item.n_z   = n_ff[2];

endmodule

FILE: rtl/core/triangle_face_normal.sv
// top level: unit face normal of one triangle, deep pipeline with output skid
//
//  channel   ports                          direction  payload
//  request   req_valid req_stall req_item   in         three vertices, q15.8
//  response  rsp_valid rsp_stall rsp_item   out        normal q1.14, degenerate
//
// one request per cycle while req_stall is low; 25 register stages (3 cross
// product stages, 5 scaling stages, 1 setup and 15 recurrence stages of one
// result bit each, and the output register).
// reset clears all valid bits and the skid flag; payload registers hold junk.
// when the response is stalled one more pipeline result is taken into the skid slot,
// then req_stall rises until the output register drains.
module triangle_face_normal (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  tfn_pkg::req_type req_item,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output tfn_pkg::rsp_type rsp_item
);
   import tfn_pkg::*;

   localparam int PipeN = 5 + Iters + 1;

   logic      en;
   logic      fr_valid;
   cross_type fr_item;

   logic signed [CrossW-1:0] n_vec [3];
   logic [CrossW-1:0]   mag_in [3];
   logic [CrossW-1:0]   mag_ff [3];
   logic [CrossW-1:0]   s2_mag_ff [3];
   logic [CrossW-1:0]   mag_or;
   logic [ShiftW-1:0]   k_in;
   logic [ShiftW-1:0]   k_ff;
   logic [MagW-1:0]     m_in [3];
   logic [MagW-1:0]     m_ff [3];
   logic [SqW-1:0]      sq_in [3];
   logic [SqW-1:0]      sq_ff [3];
   logic [SqW-1:0]      s5_sq_ff [3];
   logic [SumW-1:0]     sum_in;
   logic [SumW-1:0]     sum_ff;

   logic signed [RemW-1:0] it_d_in [Iters+1][3];
   logic signed [RemW-1:0] it_d_ff [Iters+1][3];
   logic signed [RemW-1:0] it_p_in [Iters+1][3];
   logic signed [RemW-1:0] it_p_ff [Iters+1][3];
   logic [QuotW-1:0]       it_q_in [Iters+1][3];
   logic [QuotW-1:0]       it_q_ff [Iters+1][3];
   logic [SumW-1:0]        it_s_in [Iters+1];
   logic [SumW-1:0]        it_s_ff [Iters+1];

   logic [PipeN-1:0] st_v_ff;
   logic [2:0]       st_neg_ff [PipeN];
   logic [2:0]       st_neg_in [PipeN];
   logic             st_deg_ff [PipeN];
   logic             st_deg_in [PipeN];

   logic    pipe_v;
   rsp_type pipe_out;
   logic    out_v_ff;
   rsp_type out_item_ff;
   logic    skid_full_ff;
   rsp_type skid_item_ff;

   // the pipeline moves while the skid slot is free
   assign en = !skid_full_ff;

   tfn_cross u_cross (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_valid),
      .in_item   (req_item),
      .out_valid (fr_valid),
      .out_item  (fr_item)
   );

   // magnitudes of the cross product components
   always_comb begin
      n_vec[0] = fr_item.n_x;
      n_vec[1] = fr_item.n_y;
      n_vec[2] = fr_item.n_z;
      for (int i = 0; i < 3; i++) begin
         mag_in[i] = n_vec[i][CrossW-1] ? CrossW'(-n_vec[i]) : CrossW'(n_vec[i]);
      end
   end

   // smallest shift that brings every magnitude below the limit
   always_comb begin
      mag_or = mag_ff[0] | mag_ff[1] | mag_ff[2];
      k_in   = '0;
      for (int b = LimitBit; b < CrossW; b++) begin
         if (mag_or[b]) begin
            k_in = ShiftW'(b - LimitBit + 1);
         end
      end
   end

   // scale, square and sum
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         m_in[i]  = MagW'(s2_mag_ff[i] >> k_ff);
         sq_in[i] = SqW'(m_ff[i]) * SqW'(m_ff[i]);
      end
      sum_in = SumW'(sq_ff[0]) + SumW'(sq_ff[1]) + SumW'(sq_ff[2]);
   end

   // digit recurrence: keep d = 2^30 m^2 - (2q-1)^2 s and p = (2q-1) s,
   // try one result bit per stage with shifts and adds only
   always_comb begin
      it_s_in[0] = sum_ff;
      for (int i = 0; i < 3; i++) begin
         it_d_in[0][i] = $signed(RemW'(s5_sq_ff[i]) << LimitBit) - $signed(RemW'(sum_ff));
         it_p_in[0][i] = -$signed(RemW'(sum_ff));
         it_q_in[0][i] = '0;
      end
      for (int g = 0; g < Iters; g++) begin
         it_s_in[g+1] = it_s_ff[g];
         for (int i = 0; i < 3; i++) begin
            logic signed [RemW-1:0] s_sig;
            logic signed [RemW-1:0] cand;
            logic                   take;
            s_sig = $signed(RemW'(it_s_ff[g]));
            cand  = it_d_ff[g][i] - (it_p_ff[g][i] <<< (Iters + 1 - g))
                    - (s_sig <<< (2 * (Iters - 1 - g) + 2));
            take  = !cand[RemW-1];
            it_d_in[g+1][i] = take ? cand : it_d_ff[g][i];
            it_p_in[g+1][i] = take ? it_p_ff[g][i] + (s_sig <<< (Iters - g))
                                   : it_p_ff[g][i];
            it_q_in[g+1][i] = it_q_ff[g][i] | (QuotW'(take) << (Iters - 1 - g));
         end
      end
   end

   // sign and degenerate flag ride along every stage
   always_comb begin
      st_neg_in[0] = {n_vec[2][CrossW-1], n_vec[1][CrossW-1], n_vec[0][CrossW-1]};
      st_deg_in[0] = (n_vec[0] == '0) && (n_vec[1] == '0) && (n_vec[2] == '0);
      for (int k = 1; k < PipeN; k++) begin
         st_neg_in[k] = st_neg_ff[k-1];
         st_deg_in[k] = st_deg_ff[k-1];
      end
   end

   // stage valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         st_v_ff <= '0;
      end else if (en) begin
         st_v_ff <= {st_v_ff[PipeN-2:0], fr_valid};
      end
   end

   // stage data
   always_ff @(posedge clock) begin
      if (en) begin
         mag_ff    <= mag_in;
         s2_mag_ff <= mag_ff;
         k_ff      <= k_in;
         m_ff      <= m_in;
         sq_ff     <= sq_in;
         s5_sq_ff  <= sq_ff;
         sum_ff    <= sum_in;
         it_d_ff   <= it_d_in;
         it_p_ff   <= it_p_in;
         it_q_ff   <= it_q_in;
         it_s_ff   <= it_s_in;
         st_neg_ff <= st_neg_in;
         st_deg_ff <= st_deg_in;
      end
   end

   // apply signs, force zero for a degenerate triangle
   always_comb begin
      logic [NormW-1:0] qv [3];
      logic [NormW-1:0] sv [3];
      for (int i = 0; i < 3; i++) begin
         qv[i] = NormW'(it_q_ff[Iters][i]);
         sv[i] = st_deg_ff[PipeN-1] ? '0
                 : (st_neg_ff[PipeN-1][i] ? NormW'(-qv[i]) : qv[i]);
      end
      pipe_out.normal_x   = $signed(sv[0]);
      pipe_out.normal_y   = $signed(sv[1]);
      pipe_out.normal_z   = $signed(sv[2]);
      pipe_out.degenerate = st_deg_ff[PipeN-1];
   end
   assign pipe_v = st_v_ff[PipeN-1];

   // output register and skid slot control
   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff     <= 1'b0;
         skid_full_ff <= 1'b0;
      end else if (!out_v_ff || !rsp_stall) begin
         out_v_ff     <= skid_full_ff | pipe_v;
         skid_full_ff <= 1'b0;
      end else if (pipe_v && !skid_full_ff) begin
         skid_full_ff <= 1'b1;
      end
   end

   // output register and skid slot data
   always_ff @(posedge clock) begin
      if (!out_v_ff || !rsp_stall) begin
         out_item_ff <= skid_full_ff ? skid_item_ff : pipe_out;
      end else if (!skid_full_ff) begin
         skid_item_ff <= pipe_out;
      end
   end

   assign req_stall = skid_full_ff;
   assign rsp_valid = out_v_ff;
   assign rsp_item  = out_item_ff;

   // degenerate response carries a zero vector
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.degenerate |->
         rsp_item.normal_x == 0 && rsp_item.normal_y == 0 && rsp_item.normal_z == 0)
      else $error("degenerate response with nonzero normal");

   // unit normal components stay within one
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_item.degenerate |->
         rsp_item.normal_x <= 16384 && rsp_item.normal_x >= -16384 &&
         rsp_item.normal_y <= 16384 && rsp_item.normal_y >= -16384 &&
         rsp_item.normal_z <= 16384 && rsp_item.normal_z >= -16384)
      else $error("normal component out of range");

   // skid slot only fills behind a waiting response
   assert property (@(posedge clock) disable iff (reset)
      skid_full_ff |-> out_v_ff)
      else $error("skid slot full with empty output register");

   // skid slot fills only on a stalled response
   assert property (@(posedge clock) disable iff (reset)
      $rose(skid_full_ff) |-> $past(rsp_stall) && $past(out_v_ff))
      else $error("skid slot filled without a stall");

endmodule
